### rtl/core/pid_antiwindup_settle_core_macros.svh
// Assertion macros for the PID anti-windup settle core.
// Depends on a clock named clock and a synchronous reset named reset in the including module.
`ifndef PID_ANTIWINDUP_SETTLE_CORE_MACROS_SVH
`define PID_ANTIWINDUP_SETTLE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PAS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pas_pkg.sv
// Package for the PID anti-windup settle core: default widths, register indexes
// and reset values. No dependencies.
package pas_pkg;

   // Default field widths.
   localparam int DEF_ERROR_WIDTH = 24;
   localparam int DEF_GAIN_WIDTH  = 16;

   // Fixed widths.
   localparam int SUM_W     = 32;
   localparam int DRIVE_W   = 32;
   localparam int COUNT_W   = 16;
   localparam int FRAC_BITS = 8;
   localparam int RSP_W     = ((DRIVE_W + 1 + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KP             = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KI             = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KD             = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEED      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEADY_BAND    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEADY_GOAL    = 3'd7;

   // Reset values of the registers (speeds are -127.0 and 127.0 in Q.8).
   localparam int RST_MIN_SPEED      = -32512;
   localparam int RST_MAX_SPEED      = 32512;
   localparam int RST_INTEGRAL_LIMIT = -1;
   localparam int RST_STEADY_GOAL    = 10;

endpackage

### rtl/core/pid_antiwindup_settle_core.sv
// PID controller with integral anti-windup and settle detection, three-stage pipeline.
// Depends on pas_pkg and pid_antiwindup_settle_core_macros.svh.
//
// Usage:
//   req channel carries one error sample and a clamp flag per item. rsp channel returns
//   the drive value and the settled flag for that item, in order, one result per item.
//   csr port writes the gains, speed bounds, integral limit and settle settings; write
//   them only while no item is in flight.
// Path: the accepting edge loads stage 1; the item then moves to the products stage and on
//   to the output register, which drives rsp_tvalid for it.
// Throughput: one item per cycle unless rsp_tready stalls it. The error sum, last error
//   and steady count update in the accept cycle, so the state loop is a single add,
//   saturate and compare; the three gain multiplies run in the next stage, off that loop.
// Reset: clears the pipeline, the error sum, the last error and the steady count, and
//   loads the register defaults (zero gains, speeds of -127.0 and 127.0, limit off,
//   threshold zero, target ten).
// Stall: when rsp_tready is low the output register holds its item; the stages behind it
//   keep filling, and req_tready drops only when every stage holds an item.
`include "pid_antiwindup_settle_core_macros.svh"

module pid_antiwindup_settle_core
   import pas_pkg::*;
#(
   parameter int ERROR_WIDTH = DEF_ERROR_WIDTH,
   parameter int GAIN_WIDTH  = DEF_GAIN_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: error, clamp_enable, zero fill.
   input  logic [((ERROR_WIDTH+1+7)/8)*8-1:0] req_tdata,
   // Result items.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: drive, settled, zero fill.
   output logic [RSP_W-1:0]                  rsp_tdata,
   // Register writes.
   input  logic                              csr_wen,
   input  logic [CSR_INDEX_W-1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0]             csr_wdata
);

   localparam int E       = ERROR_WIDTH;
   localparam int G       = GAIN_WIDTH;
   localparam int DIFF_W  = E + 1;
   localparam int WIDE_W  = (DIFF_W > SUM_W) ? DIFF_W : SUM_W;
   localparam int ACC_W   = G + WIDE_W + 2;
   localparam int RAW_W   = ACC_W - FRAC_BITS;
   localparam int MAG_W   = RAW_W + 1;
   localparam int PKP_W   = G + E;
   localparam int PKI_W   = G + SUM_W;
   localparam int PKD_W   = G + DIFF_W;
   localparam int SWIDE_W = SUM_W + 2;

   localparam logic signed [SWIDE_W-1:0] SUM_MAX = SWIDE_W'(signed'(32'h7FFF_FFFF));
   localparam logic signed [SWIDE_W-1:0] SUM_MIN = SWIDE_W'(signed'(32'h8000_0000));
   localparam logic signed [RAW_W-1:0]   RAW_MAX = RAW_W'(signed'(32'h7FFF_FFFF));
   localparam logic signed [RAW_W-1:0]   RAW_MIN = RAW_W'(signed'(32'h8000_0000));
   localparam logic [COUNT_W-1:0]        COUNT_MAX = {COUNT_W{1'b1}};

   // Configuration registers.
   logic signed [G-1:0]       kp_ff, ki_ff, kd_ff;
   logic signed [E-1:0]       min_speed_ff, max_speed_ff;
   logic signed [SUM_W-1:0]   limit_ff;
   logic [E-1:0]              threshold_ff;
   logic [COUNT_W-1:0]        target_ff;

   // Controller state.
   logic signed [E-1:0]       last_err_ff, last_err_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   // Stage 1: state update results.
   logic                      s1_valid_ff;
   logic signed [E-1:0]       s1_err_ff;
   logic signed [SUM_W-1:0]   s1_sum_ff;
   logic signed [DIFF_W-1:0]  s1_diff_ff, diff_in;
   logic                      s1_clamp_ff;
   logic                      s1_settled_ff, settled_in;

   // Stage 2: products.
   logic                      s2_valid_ff;
   logic signed [PKP_W-1:0]   s2_pkp_ff, pkp_in;
   logic signed [PKI_W-1:0]   s2_pki_ff, pki_in;
   logic signed [PKD_W-1:0]   s2_pkd_ff, pkd_in;
   logic                      s2_clamp_ff;
   logic                      s2_settled_ff;

   // Output register.
   logic                      out_valid_ff;
   logic [DRIVE_W-1:0]        out_drive_ff, drive_in;
   logic                      out_settled_ff;

   // Handshake and datapath wires.
   logic                      out_ready, s2_ready, s1_ready, accept;
   logic signed [E-1:0]       err;
   logic                      clamp_en;
   logic                      flip;
   logic signed [SUM_W-1:0]   sum_base;
   logic signed [SWIDE_W-1:0] sum_wide;
   logic signed [SUM_W-1:0]   sum_sat;
   logic [DIFF_W-1:0]         adiff;
   logic                      steady;
   logic signed [ACC_W-1:0]   acc;
   logic signed [RAW_W-1:0]   raw;
   logic signed [MAG_W-1:0]   mag, mag_lo, mag_hi, min_ext, max_ext, drive_mag;
   logic [DRIVE_W-1:0]        drive_free;

   // Pipeline flow: a stage takes a new item when it is empty or its item moves on.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_settled_ff, out_drive_ff});

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         min_speed_ff <= E'(RST_MIN_SPEED);
         max_speed_ff <= E'(RST_MAX_SPEED);
         limit_ff     <= SUM_W'(RST_INTEGRAL_LIMIT);
         threshold_ff <= '0;
         target_ff    <= COUNT_W'(RST_STEADY_GOAL);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_KP:             kp_ff        <= csr_wdata[G-1:0];
            CSR_KI:             ki_ff        <= csr_wdata[G-1:0];
            CSR_KD:             kd_ff        <= csr_wdata[G-1:0];
            CSR_MIN_SPEED:      min_speed_ff <= csr_wdata[E-1:0];
            CSR_MAX_SPEED:      max_speed_ff <= csr_wdata[E-1:0];
            CSR_INTEGRAL_LIMIT: limit_ff     <= csr_wdata[SUM_W-1:0];
            CSR_STEADY_BAND:    threshold_ff <= csr_wdata[E-1:0];
            CSR_STEADY_GOAL:    target_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // State update for the incoming item: sum reset on sign flip, saturating add,
   // optional limit clamp, and the steady counter.
   always_comb begin
      err      = signed'(req_tdata[E-1:0]);
      clamp_en = req_tdata[E];

      flip = (!err[E-1] && (err != '0) && last_err_ff[E-1]) ||
             (err[E-1] && !last_err_ff[E-1] && (last_err_ff != '0));
      sum_base = flip ? '0 : sum_ff;
      sum_wide = SWIDE_W'(sum_base) + SWIDE_W'(err);
      if (sum_wide > SUM_MAX) begin
         sum_sat = SUM_W'(SUM_MAX);
      end else if (sum_wide < SUM_MIN) begin
         sum_sat = SUM_W'(SUM_MIN);
      end else begin
         sum_sat = SUM_W'(sum_wide);
      end
      sum_in = sum_sat;
      if (!limit_ff[SUM_W-1]) begin
         if (sum_sat > limit_ff) begin
            sum_in = limit_ff;
         end else if (sum_sat < -limit_ff) begin
            sum_in = -limit_ff;
         end
      end

      diff_in = DIFF_W'(err) - DIFF_W'(last_err_ff);
      adiff   = diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : DIFF_W'(diff_in);
      steady  = adiff < DIFF_W'(threshold_ff);
      if (!steady) begin
         count_in = '0;
      end else if (count_ff == COUNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + COUNT_W'(1);
      end
      settled_in  = count_in >= target_ff;
      last_err_in = err;
   end

   // State and stage 1 registers load on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            last_err_ff <= last_err_in;
            sum_ff      <= sum_in;
            count_ff    <= count_in;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff     <= err;
         s1_sum_ff     <= sum_in;
         s1_diff_ff    <= diff_in;
         s1_clamp_ff   <= clamp_en;
         s1_settled_ff <= settled_in;
      end
   end

   // Stage 2: the three gain products.
   always_comb begin
      pkp_in = s1_err_ff * kp_ff;
      pki_in = s1_sum_ff * ki_ff;
      pkd_in = s1_diff_ff * kd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_pkp_ff     <= pkp_in;
         s2_pki_ff     <= pki_in;
         s2_pkd_ff     <= pkd_in;
         s2_clamp_ff   <= s1_clamp_ff;
         s2_settled_ff <= s1_settled_ff;
      end
   end

   // Stage 3: sum, scale back to Q.8 with floor, then saturate or clamp the magnitude.
   always_comb begin
      acc = ACC_W'(s2_pkp_ff) + ACC_W'(s2_pki_ff) + ACC_W'(s2_pkd_ff);
      raw = signed'(acc[ACC_W-1:FRAC_BITS]);

      if (raw > RAW_MAX) begin
         drive_free = DRIVE_W'(RAW_MAX);
      end else if (raw < RAW_MIN) begin
         drive_free = DRIVE_W'(RAW_MIN);
      end else begin
         drive_free = DRIVE_W'(raw);
      end

      // Magnitude is raised to the lower bound first, so the upper bound wins.
      min_ext = MAG_W'(min_speed_ff);
      max_ext = MAG_W'(max_speed_ff);
      mag     = raw[RAW_W-1] ? -MAG_W'(raw) : MAG_W'(raw);
      mag_lo  = (mag < min_ext) ? min_ext : mag;
      mag_hi  = (mag_lo > max_ext) ? max_ext : mag_lo;
      drive_mag = raw[RAW_W-1] ? -mag_hi : mag_hi;

      if (!s2_clamp_ff) begin
         drive_in = drive_free;
      end else if (raw == '0) begin
         drive_in = '0;
      end else begin
         drive_in = drive_mag[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         out_drive_ff   <= drive_in;
         out_settled_ff <= s2_settled_ff;
      end
   end

   // Checks on the state loop and the pipeline.
   `PAS_ASSERT_NEXT(a_sum_within_limit, accept && !limit_ff[SUM_W-1], (sum_ff <= $past(limit_ff)) && (sum_ff >= -$past(limit_ff)), "error sum outside the integral limit")
   `PAS_ASSERT_NEXT(a_count_step, accept, (count_ff == '0) || (count_ff == $past(count_ff) + COUNT_W'(1)) || (count_ff == COUNT_MAX), "steady count moved by more than one")
   `PAS_ASSERT_NEXT(a_state_holds, !accept, $stable(sum_ff) && $stable(last_err_ff) && $stable(count_ff), "controller state changed without an item")
   `PAS_ASSERT_SAME(a_out_from_stage2, $rose(out_valid_ff), $past(s2_valid_ff), "result appeared without an item in stage 2")

endmodule
